>>> hw/rtl/rmq_pkg.sv
// ----------------------------------------------------------------------------
// rmq_pkg: shared constants for the rotation matrix to quaternion block
// Field widths and the default fraction width of the rotation entries.
// ----------------------------------------------------------------------------
package rmq_pkg;
    localparam int ROT_W          = 16;
    localparam int POS_W          = 32;
    localparam int ROT_FRAC_BITS  = 14;

    typedef enum logic [1:0] {
        MAIN_X = 2'd0,
        MAIN_Y = 2'd1,
        MAIN_Z = 2'd2,
        MAIN_W = 2'd3
    } t_main;
endpackage

>>> hw/rtl/rmq_divider.sv
// ----------------------------------------------------------------------------
// rmq_divider: pipelined restoring divider
// One quotient bit per stage; a new division may enter every cycle.
// ----------------------------------------------------------------------------
module rmq_divider #(
    parameter int NW = 36,
    parameter int DW = 20
) (
    input  logic          i_clk,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic [NW-1:0] o_quo
);
    logic [NW-1:0] r_num [NW+1];
    logic [DW-1:0] r_den [NW+1];
    logic [DW:0]   r_rem [NW+1];
    logic [NW-1:0] r_quo [NW+1];

    always_comb begin
        r_num[0] = i_num;
        r_den[0] = i_den;
        r_rem[0] = '0;
        r_quo[0] = '0;
    end

    for (genvar k = 0; k < NW; k++) begin : g_st
        logic [DW+1:0] n_try;
        logic [DW+1:0] n_sh;
        always_comb begin
            n_sh  = {r_rem[k], r_num[k][NW-1-k]};
            n_try = n_sh - {2'b00, r_den[k]};
        end
        always_ff @(posedge i_clk) begin
            r_num[k+1] <= r_num[k];
            r_den[k+1] <= r_den[k];
            if (!n_try[DW+1]) begin
                r_rem[k+1] <= n_try[DW:0];
                r_quo[k+1] <= r_quo[k] | (NW'(1) << (NW-1-k));
            end else begin
                r_rem[k+1] <= n_sh[DW:0];
                r_quo[k+1] <= r_quo[k];
            end
        end
    end

    assign o_quo = r_quo[NW];
endmodule

>>> hw/rtl/rotation_matrix_to_quaternion.sv
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion: pose matrix to position and quaternion
//
// Issue a request by raising start with a 3x3 rotation (signed fixed point,
// ROT_FRAC_BITS fraction bits) and a Q16.16 translation. busy is always
// low, so a request is taken in every cycle that start is high.
// The result appears on the o_ ports for one cycle, flagged by o_done.
// Pipeline stages, in order: two of branch selection and argument setup,
// one per root bit of the square root (SQ_W stages, 18 at the default
// fraction width), one of divider setup, one per quotient bit of the three
// parallel dividers (NUM_W, 31), and one saturate stage. The square root
// stages and divider stages set the latency; throughput is one pose per
// cycle. The receiver cannot stall; results are never held.
// Reset clears the valid bits of the pipeline; the data registers keep
// whatever they held and are ignored.
// Translation rides along the pipeline unchanged. A non-positive square
// root argument zeroes the quaternion and raises o_degenerate.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion
    import rmq_pkg::*;
#(
    parameter int P_FRAC = ROT_FRAC_BITS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    output logic                    o_done,
    input  logic signed [ROT_W-1:0] i_r00, i_r01, i_r02,
    input  logic signed [ROT_W-1:0] i_r10, i_r11, i_r12,
    input  logic signed [ROT_W-1:0] i_r20, i_r21, i_r22,
    input  logic signed [POS_W-1:0] i_tx, i_ty, i_tz,
    output logic signed [POS_W-1:0] o_pos_x, o_pos_y, o_pos_z,
    output logic signed [ROT_W-1:0] o_quat_x, o_quat_y, o_quat_z, o_quat_w,
    output logic                    o_degenerate
);
    // A < 2^F + 3*32768, so it fits in max(19, F+2) bits. Radicand A<<(F+2).
    localparam int A_W   = ((P_FRAC + 2) > 19) ? (P_FRAC + 2) : 19;
    localparam int SQ_IN = A_W + P_FRAC + 2 + ((A_W + P_FRAC) % 2);
    localparam int SQ_W  = SQ_IN / 2;           // root width
    localparam int NSQ   = SQ_W;                // one root bit per stage
    localparam int D_W   = ROT_W + 1;           // off-diagonal sum width
    localparam int NUM_W = D_W + P_FRAC;        // |D|<<F plus rounding
    localparam int LAT   = 2 + NSQ + 1 + NUM_W + 1;

    assign busy = 1'b0;

    // ---------------- stage 1: trace, diagonal compares, sums ---------------
    logic                       r1_v;
    logic signed [ROT_W+1:0]    r1_t;
    logic                       r1_x, r1_y;
    logic signed [ROT_W-1:0]    r1_r00, r1_r11, r1_r22;
    logic signed [D_W-1:0]      r1_dm [2][3];   // [branch-set][k]
    logic [3*POS_W-1:0]         r1_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_v <= 1'b0;
        else          r1_v <= start;
        r1_t   <= (ROT_W+2)'(i_r00) + (ROT_W+2)'(i_r11) + (ROT_W+2)'(i_r22);
        r1_x   <= (i_r00 > i_r11) && (i_r00 > i_r22);
        r1_y   <= (i_r11 > i_r22);
        r1_r00 <= i_r00; r1_r11 <= i_r11; r1_r22 <= i_r22;
        r1_pos <= {i_tx, i_ty, i_tz};
        r1_dm[0][0] <= D_W'(i_r21) - D_W'(i_r12);
        r1_dm[0][1] <= D_W'(i_r02) - D_W'(i_r20);
        r1_dm[0][2] <= D_W'(i_r10) - D_W'(i_r01);
        r1_dm[1][0] <= D_W'(i_r01) + D_W'(i_r10);
        r1_dm[1][1] <= D_W'(i_r02) + D_W'(i_r20);
        r1_dm[1][2] <= D_W'(i_r12) + D_W'(i_r21);
    end

    // ---------------- stage 2: branch, argument, differences ----------------
    logic                    r2_v, r2_deg;
    t_main                   r2_m;
    logic [A_W-1:0]          r2_a;
    logic signed [D_W-1:0]   r2_d [3];
    logic [3*POS_W-1:0]      r2_pos;
    logic signed [A_W+1:0]   n_a;
    t_main                   n_m;
    logic signed [D_W-1:0]   n_d [3];

    always_comb begin
        if (r1_t > 0) begin
            n_m = MAIN_W;
            n_a = (A_W+2)'(r1_t) + (A_W+2)'(1 << P_FRAC);
            n_d[0] = r1_dm[0][0]; n_d[1] = r1_dm[0][1]; n_d[2] = r1_dm[0][2];
        end else if (r1_x) begin
            n_m = MAIN_X;
            n_a = (A_W+2)'(1 << P_FRAC) + (A_W+2)'(r1_r00)
                - (A_W+2)'(r1_r11) - (A_W+2)'(r1_r22);
            n_d[0] = r1_dm[0][0]; n_d[1] = r1_dm[1][0]; n_d[2] = r1_dm[1][1];
        end else if (r1_y) begin
            n_m = MAIN_Y;
            n_a = (A_W+2)'(1 << P_FRAC) + (A_W+2)'(r1_r11)
                - (A_W+2)'(r1_r00) - (A_W+2)'(r1_r22);
            n_d[0] = r1_dm[0][1]; n_d[1] = r1_dm[1][0]; n_d[2] = r1_dm[1][2];
        end else begin
            n_m = MAIN_Z;
            n_a = (A_W+2)'(1 << P_FRAC) + (A_W+2)'(r1_r22)
                - (A_W+2)'(r1_r00) - (A_W+2)'(r1_r11);
            n_d[0] = r1_dm[0][2]; n_d[1] = r1_dm[1][1]; n_d[2] = r1_dm[1][2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_v <= 1'b0;
        else          r2_v <= r1_v;
        r2_m   <= n_m;
        r2_deg <= (n_a <= 0);
        r2_a   <= (n_a <= 0) ? A_W'(1) : n_a[A_W-1:0];
        r2_d   <= n_d;
        r2_pos <= r1_pos;
    end

    // ---------------- square root: one result bit per stage -----------------
    // Digit-by-digit: at step k, try setting root bit (SQ_W-1-k).
    logic [SQ_IN-1:0]      s_x   [NSQ+1];
    logic [SQ_W-1:0]       s_r   [NSQ+1];
    logic [SQ_IN+1:0]      s_rem [NSQ+1];
    logic                  s_v   [NSQ+1];
    logic                  s_dg  [NSQ+1];
    t_main                 s_m   [NSQ+1];
    logic signed [D_W-1:0] s_d   [NSQ+1][3];
    logic [3*POS_W-1:0]    s_pos [NSQ+1];

    always_comb begin
        s_x[0]   = SQ_IN'(r2_a) << (P_FRAC + 2);
        s_r[0]   = '0;
        s_rem[0] = '0;
        s_v[0]   = r2_v;
        s_dg[0]  = r2_deg;
        s_m[0]   = r2_m;
        s_d[0]   = r2_d;
        s_pos[0] = r2_pos;
    end

    for (genvar k = 0; k < NSQ; k++) begin : g_sq
        logic [SQ_IN+1:0] n_rem, n_trial;
        always_comb begin
            n_rem   = (s_rem[k] << 2)
                    | (SQ_IN+2)'(s_x[k][SQ_IN-1-2*k -: 2]);
            n_trial = (SQ_IN+2)'({s_r[k], 2'b01});
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) s_v[k+1] <= 1'b0;
            else          s_v[k+1] <= s_v[k];
            s_x[k+1]   <= s_x[k];
            s_dg[k+1]  <= s_dg[k];
            s_m[k+1]   <= s_m[k];
            s_d[k+1]   <= s_d[k];
            s_pos[k+1] <= s_pos[k];
            if (n_rem >= n_trial) begin
                s_rem[k+1] <= n_rem - n_trial;
                s_r[k+1]   <= {s_r[k][SQ_W-2:0], 1'b1};
            end else begin
                s_rem[k+1] <= n_rem;
                s_r[k+1]   <= {s_r[k][SQ_W-2:0], 1'b0};
            end
        end
    end

    // ---------------- divider setup ------------------------------------------
    logic                  r3_v, r3_dg;
    t_main                 r3_m;
    logic [SQ_W-1:0]       r3_s;
    logic [NUM_W-1:0]      r3_num [3];
    logic [2:0]            r3_neg;
    logic [3*POS_W-1:0]    r3_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_v <= 1'b0;
        else          r3_v <= s_v[NSQ];
        r3_dg  <= s_dg[NSQ];
        r3_m   <= s_m[NSQ];
        r3_s   <= s_r[NSQ];
        r3_pos <= s_pos[NSQ];
        for (int j = 0; j < 3; j++) begin
            r3_neg[j] <= s_d[NSQ][j][D_W-1];
            // |D|<<F + S/2, magnitude of D fits in D_W bits unsigned
            r3_num[j] <= (NUM_W'($unsigned(s_d[NSQ][j][D_W-1] ? -s_d[NSQ][j]
                                                               : s_d[NSQ][j]))
                          << P_FRAC) + NUM_W'(s_r[NSQ] >> 1);
        end
    end

    logic [NUM_W-1:0] q_mag [3];
    for (genvar j = 0; j < 3; j++) begin : g_div
        rmq_divider #(.NW(NUM_W), .DW(SQ_W)) u_div (
            .i_clk (i_clk),
            .i_num (r3_num[j]),
            .i_den (r3_s),
            .o_quo (q_mag[j])
        );
    end

    // side channel delayed to match divider depth
    logic               p_v   [NUM_W+1];
    logic               p_dg  [NUM_W+1];
    t_main              p_m   [NUM_W+1];
    logic [SQ_W-1:0]    p_s   [NUM_W+1];
    logic [2:0]         p_ng  [NUM_W+1];
    logic [3*POS_W-1:0] p_pos [NUM_W+1];

    always_comb begin
        p_v[0] = r3_v; p_dg[0] = r3_dg; p_m[0] = r3_m;
        p_s[0] = r3_s; p_ng[0] = r3_neg; p_pos[0] = r3_pos;
    end

    for (genvar k = 0; k < NUM_W; k++) begin : g_dly
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) p_v[k+1] <= 1'b0;
            else          p_v[k+1] <= p_v[k];
            p_dg[k+1]  <= p_dg[k];
            p_m[k+1]   <= p_m[k];
            p_s[k+1]   <= p_s[k];
            p_ng[k+1]  <= p_ng[k];
            p_pos[k+1] <= p_pos[k];
        end
    end

    // ---------------- saturate and place -------------------------------------
    function automatic logic [ROT_W-1:0] sat_mag(input logic [NUM_W-1:0] m,
                                                 input logic neg);
        logic [NUM_W:0] v;
        begin
            v = {1'b0, m};
            if (!neg) sat_mag = (v > (NUM_W+1)'(32767)) ? ROT_W'(32767) : v[ROT_W-1:0];
            else      sat_mag = (v > (NUM_W+1)'(32768)) ? ROT_W'(32768)
                                                         : ROT_W'(-v[ROT_W-1:0]);
        end
    endfunction

    logic [ROT_W-1:0] n_e [3];
    logic [ROT_W-1:0] n_main;
    logic [SQ_W:0]    n_mw;

    always_comb begin
        for (int j = 0; j < 3; j++) n_e[j] = sat_mag(q_mag[j], p_ng[NUM_W][j]);
        n_mw   = ({1'b0, p_s[NUM_W]} + (SQ_W+1)'(2)) >> 2;
        n_main = (n_mw > (SQ_W+1)'(32767)) ? ROT_W'(32767) : n_mw[ROT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_done <= 1'b0;
        else          o_done <= p_v[NUM_W];
        o_pos_x      <= p_pos[NUM_W][3*POS_W-1 -: POS_W];
        o_pos_y      <= p_pos[NUM_W][2*POS_W-1 -: POS_W];
        o_pos_z      <= p_pos[NUM_W][POS_W-1:0];
        o_degenerate <= p_dg[NUM_W];
        if (p_dg[NUM_W]) begin
            o_quat_x <= '0; o_quat_y <= '0; o_quat_z <= '0; o_quat_w <= '0;
        end else begin
            case (p_m[NUM_W])
                MAIN_W: begin
                    o_quat_w <= n_main; o_quat_x <= n_e[0];
                    o_quat_y <= n_e[1]; o_quat_z <= n_e[2];
                end
                MAIN_X: begin
                    o_quat_x <= n_main; o_quat_w <= n_e[0];
                    o_quat_y <= n_e[1]; o_quat_z <= n_e[2];
                end
                MAIN_Y: begin
                    o_quat_y <= n_main; o_quat_w <= n_e[0];
                    o_quat_x <= n_e[1]; o_quat_z <= n_e[2];
                end
                default: begin
                    o_quat_z <= n_main; o_quat_w <= n_e[0];
                    o_quat_x <= n_e[1]; o_quat_y <= n_e[2];
                end
            endcase
        end
    end

    logic unused_lat;
    assign unused_lat = (LAT > 0);
endmodule
